### rtl/core/cbad_pkg.sv
`default_nettype none

package cbad_pkg;

	localparam int unsigned ADDR_W = 24;
	localparam int unsigned OFFS_W = 23;
	localparam int unsigned DATA_W = 8;
	localparam int unsigned CFG_W = 24;
	localparam int unsigned ROMSZ_W = 24;
	localparam int unsigned SMASK_W = 20;

	localparam logic [7:0] BANK_WRAM_LO = 8'h7E;
	localparam logic [7:0] BANK_WRAM_HI = 8'h7F;
	localparam logic [6:0] BANK_SRAM_LO = 7'h70;
	localparam logic [6:0] BANK_SRAM_HI = 7'h7D;
	localparam logic [15:0] OFS_IO_LO = 16'h2100;
	localparam logic [15:0] OFS_IO_HI = 16'h6000;
	localparam logic [15:0] OFS_LOWRAM_END = 16'h2000;

	typedef enum logic [1:0] {
		MAP_LOROM   = 2'd0,
		MAP_HIROM   = 2'd1,
		MAP_EXHIROM = 2'd2,
		MAP_NONE    = 2'd3
	} map_mode_t;

	typedef enum logic [1:0] {
		REG_MAP_MODE     = 2'd0,
		REG_ROM_BYTES    = 2'd1,
		REG_SRAM_PRESENT = 2'd2,
		REG_SRAM_MASK    = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		TGT_WRAM  = 3'd0,
		TGT_ROM   = 3'd1,
		TGT_SRAM  = 3'd2,
		TGT_IO    = 3'd3,
		TGT_OPEN  = 3'd4,
		TGT_ROMWR = 3'd5
	} target_t;

	typedef struct packed {
		map_mode_t            map_mode;
		logic [ROMSZ_W-1:0]   rom_bytes;
		logic                 sram_present;
		logic [SMASK_W-1:0]   sram_mask;
	} cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] bus_address;
		logic              is_read;
		logic [DATA_W-1:0] write_data;
	} access_t;

	typedef struct packed {
		target_t           target;
		logic [OFFS_W-1:0] phys_offset;
		logic              write_enable;
		logic [DATA_W-1:0] write_data_out;
	} result_t;

endpackage

`default_nettype wire

### rtl/core/cbad_ifs.sv
`default_nettype none

interface cbad_in_if;
	logic                         valid;
	logic                         ready;
	logic [cbad_pkg::ADDR_W-1:0] bus_address;
	logic                         is_read;
	logic [cbad_pkg::DATA_W-1:0] write_data;

	modport source (output valid, output bus_address, output is_read, output write_data,
		input ready);
	modport sink (input valid, input bus_address, input is_read, input write_data,
		output ready);
endinterface

interface cbad_out_if;
	logic                         valid;
	logic                         ready;
	cbad_pkg::target_t            target;
	logic [cbad_pkg::OFFS_W-1:0] phys_offset;
	logic                         write_enable;
	logic [cbad_pkg::DATA_W-1:0] write_data_out;

	modport source (output valid, output target, output phys_offset, output write_enable,
		output write_data_out, input ready);
	modport sink (input valid, input target, input phys_offset, input write_enable,
		input write_data_out, output ready);
endinterface

`default_nettype wire

### rtl/core/cbad_cfg_regs.sv
`default_nettype none

module cbad_cfg_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_write_en,
	input  wire cbad_pkg::reg_index_t       cfg_index,
	input  wire logic [cbad_pkg::CFG_W-1:0] cfg_data,
	output cbad_pkg::cfg_t                  cfg
);

	cbad_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_mode     <= cbad_pkg::MAP_NONE;
			cfg_q.rom_bytes    <= '0;
			cfg_q.sram_present <= 1'b0;
			cfg_q.sram_mask    <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				cbad_pkg::REG_MAP_MODE: begin
					cfg_q.map_mode <= cbad_pkg::map_mode_t'(cfg_data[1:0]);
				end
				cbad_pkg::REG_ROM_BYTES: begin
					cfg_q.rom_bytes <= cfg_data[cbad_pkg::ROMSZ_W-1:0];
				end
				cbad_pkg::REG_SRAM_PRESENT: begin
					cfg_q.sram_present <= cfg_data[0];
				end
				cbad_pkg::REG_SRAM_MASK: begin
					cfg_q.sram_mask <= cfg_data[cbad_pkg::SMASK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### rtl/core/cbad_decode.sv
`default_nettype none

module cbad_decode (
	input  wire cbad_pkg::cfg_t    cfg,
	input  wire cbad_pkg::access_t acc,
	output cbad_pkg::result_t      res
);

	logic [7:0]                   bank;
	logic [6:0]                   rb;
	logic [15:0]                  ofs;
	logic                         wram_bank;
	logic                         io_range;
	logic                         rom_sel;
	logic [cbad_pkg::OFFS_W-1:0]  rom_off;
	logic [cbad_pkg::SMASK_W-1:0] sram_raw;
	cbad_pkg::target_t            tgt;
	logic [cbad_pkg::OFFS_W-1:0]  off;
	logic                         we;

	assign bank      = acc.bus_address[23:16];
	assign rb        = bank[6:0];
	assign ofs       = acc.bus_address[15:0];
	assign wram_bank = (bank == cbad_pkg::BANK_WRAM_LO) || (bank == cbad_pkg::BANK_WRAM_HI);
	assign io_range  = (ofs >= cbad_pkg::OFS_IO_LO) && (ofs < cbad_pkg::OFS_IO_HI);

	always_comb begin
		tgt      = cbad_pkg::TGT_OPEN;
		off      = '0;
		rom_sel  = 1'b0;
		rom_off  = '0;
		sram_raw = '0;
		unique case (cfg.map_mode)
			cbad_pkg::MAP_LOROM: begin
				if (wram_bank) begin
					tgt = cbad_pkg::TGT_WRAM;
					off = {6'd0, acc.bus_address[16:0]};
				end else if (ofs[15]) begin
					rom_sel = 1'b1;
					rom_off = {1'b0, rb, ofs[14:0]};
				end else if (!rb[6]) begin
					if (ofs < cbad_pkg::OFS_LOWRAM_END) begin
						tgt = cbad_pkg::TGT_WRAM;
						off = {7'd0, ofs};
					end else if (io_range) begin
						tgt = cbad_pkg::TGT_IO;
						off = {7'd0, ofs};
					end
				end else if ((rb >= cbad_pkg::BANK_SRAM_LO) && (rb <= cbad_pkg::BANK_SRAM_HI)
					&& cfg.sram_present) begin
					sram_raw = {1'b0, rb[3:0], ofs[14:0]};
					tgt      = cbad_pkg::TGT_SRAM;
					off      = {3'd0, sram_raw & cfg.sram_mask};
				end
			end
			cbad_pkg::MAP_HIROM, cbad_pkg::MAP_EXHIROM: begin
				if (wram_bank) begin
					tgt = cbad_pkg::TGT_WRAM;
					off = {6'd0, acc.bus_address[16:0]};
				end else if (rb[6]) begin
					rom_sel = 1'b1;
					rom_off = {(cfg.map_mode == cbad_pkg::MAP_EXHIROM) && !bank[7], rb[5:0], ofs};
				end else if (ofs[15]) begin
					rom_sel = 1'b1;
					rom_off = {1'b0, bank[5:0], ofs};
				end else if (ofs < cbad_pkg::OFS_LOWRAM_END) begin
					tgt = cbad_pkg::TGT_WRAM;
					off = {7'd0, ofs};
				end else if (io_range) begin
					tgt = cbad_pkg::TGT_IO;
					off = {7'd0, ofs};
				end else if ((ofs >= cbad_pkg::OFS_IO_HI) && cfg.sram_present) begin
					sram_raw = {2'd0, bank[4:0], ofs[12:0]};
					tgt      = cbad_pkg::TGT_SRAM;
					off      = {3'd0, sram_raw & cfg.sram_mask};
				end
			end
			default: begin
			end
		endcase

		if (rom_sel && ({1'b0, rom_off} < cfg.rom_bytes)) begin
			tgt = acc.is_read ? cbad_pkg::TGT_ROM : cbad_pkg::TGT_ROMWR;
			off = rom_off;
		end
	end

	assign we = !acc.is_read && ((tgt == cbad_pkg::TGT_WRAM) || (tgt == cbad_pkg::TGT_SRAM)
		|| (tgt == cbad_pkg::TGT_IO));

	assign res.target         = tgt;
	assign res.phys_offset    = off;
	assign res.write_enable   = we;
	assign res.write_data_out = we ? acc.write_data : '0;

endmodule

`default_nettype wire

### rtl/core/cartridge_bus_address_decoder_unit.sv
// Cartridge bus address decoder.
// Channel in carries one bus access per transfer: 24-bit address, read flag
// and write byte. Channel out carries one decode result per access: target
// region, offset inside it, write enable and the write byte passed through.
// Both channels transfer on a clock edge with valid and ready high.
// The configuration port writes map mode, ROM size, save RAM presence and
// save RAM mask; write it only while no access is in flight.
// A result is offered on out once its access has passed the input register,
// the decode logic and the result register.
// The unit accepts one access per cycle while out does not stall.
// When out stalls, both stages hold and in.ready drops once both are full;
// ready returns in the cycle out takes its result.
// Reset clears both stage valids and loads map mode unmapped, so every
// access decodes as open bus until configured.
`default_nettype none

module cartridge_bus_address_decoder_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	cbad_in_if.sink                         in,
	cbad_out_if.source                      out,
	input  wire logic                       cfg_write_en,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [cbad_pkg::CFG_W-1:0] cfg_data
);

	cbad_pkg::cfg_t    cfg;
	cbad_pkg::access_t acc_s1;
	cbad_pkg::result_t res_comb;
	cbad_pkg::result_t res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              adv_s2;
	logic              adv_s1;

	cbad_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cbad_pkg::reg_index_t'(cfg_index)),
		.cfg_data     (cfg_data),
		.cfg          (cfg)
	);

	cbad_decode u_decode (
		.cfg (cfg),
		.acc (acc_s1),
		.res (res_comb)
	);

	assign adv_s2   = !valid_s2 || out.ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in.valid) begin
			acc_s1.bus_address <= in.bus_address;
			acc_s1.is_read     <= in.is_read;
			acc_s1.write_data  <= in.write_data;
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign out.valid          = valid_s2;
	assign out.target         = res_s2.target;
	assign out.phys_offset    = res_s2.phys_offset;
	assign out.write_enable   = res_s2.write_enable;
	assign out.write_data_out = res_s2.write_data_out;

endmodule

`default_nettype wire

### test/cartridge_bus_address_decoder_unit_test.sv
`timescale 1ns / 100ps

module cartridge_bus_address_decoder_unit_test;

	logic clk;
	logic arst_n;
	logic cfg_write_en;
	cbad_pkg::reg_index_t cfg_index;
	logic [cbad_pkg::CFG_W-1:0] cfg_data;

	cbad_in_if in_ch();
	cbad_out_if out_ch();

	cartridge_bus_address_decoder_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in           (in_ch),
		.out          (out_ch),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	cbad_pkg::cfg_t map_cfg;
	cbad_pkg::result_t pending_decodes[$];
	int unsigned src_idle_pct;
	int unsigned sink_stall_pct;
	int unsigned decode_errors;
	int unsigned mismatch_reports;
	int unsigned accesses_sent;
	int unsigned decodes_checked;
	int unsigned settings_applied;
	int unsigned target_hits[6];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("cartridge_bus_address_decoder_unit regression: fail");
		$finish;
	end

	function automatic void rom_window(input int unsigned lin, input logic rd,
			output cbad_pkg::target_t tgt, output int unsigned pos);
		if (lin >= 32'(map_cfg.rom_bytes)) begin
			tgt = cbad_pkg::TGT_OPEN;
			pos = 0;
		end else begin
			tgt = rd ? cbad_pkg::TGT_ROM : cbad_pkg::TGT_ROMWR;
			pos = lin;
		end
	endfunction

	function automatic cbad_pkg::result_t predict_decode(input cbad_pkg::access_t a);
		cbad_pkg::result_t r;
		cbad_pkg::target_t tgt;
		int unsigned pos;
		int unsigned lin;
		int unsigned bank;
		int unsigned ofs;
		int unsigned rb;
		bank = 32'(a.bus_address[23:16]);
		ofs = 32'(a.bus_address[15:0]);
		rb = bank & 32'h7F;
		tgt = cbad_pkg::TGT_OPEN;
		pos = 0;
		if (map_cfg.map_mode == cbad_pkg::MAP_LOROM) begin
			if (bank == 32'(cbad_pkg::BANK_WRAM_LO) || bank == 32'(cbad_pkg::BANK_WRAM_HI)) begin
				tgt = cbad_pkg::TGT_WRAM;
				pos = 32'(a.bus_address) & 32'h1FFFF;
			end else if (ofs >= 32'h8000) begin
				rom_window(rb * 32'h8000 + ofs - 32'h8000, a.is_read, tgt, pos);
			end else if (rb <= 32'h3F) begin
				if (ofs < 32'(cbad_pkg::OFS_LOWRAM_END)) begin
					tgt = cbad_pkg::TGT_WRAM;
					pos = ofs;
				end else if (ofs >= 32'(cbad_pkg::OFS_IO_LO)
						&& ofs < 32'(cbad_pkg::OFS_IO_HI)) begin
					tgt = cbad_pkg::TGT_IO;
					pos = ofs;
				end
			end else if (rb >= 32'(cbad_pkg::BANK_SRAM_LO) && rb <= 32'(cbad_pkg::BANK_SRAM_HI)
					&& map_cfg.sram_present) begin
				tgt = cbad_pkg::TGT_SRAM;
				pos = ((rb - 32'(cbad_pkg::BANK_SRAM_LO)) * 32'h8000 + ofs)
					& 32'(map_cfg.sram_mask);
			end
		end else if (map_cfg.map_mode == cbad_pkg::MAP_HIROM
				|| map_cfg.map_mode == cbad_pkg::MAP_EXHIROM) begin
			if (bank == 32'(cbad_pkg::BANK_WRAM_LO) || bank == 32'(cbad_pkg::BANK_WRAM_HI)) begin
				tgt = cbad_pkg::TGT_WRAM;
				pos = 32'(a.bus_address) & 32'h1FFFF;
			end else if (rb >= 32'h40) begin
				lin = (rb - 32'h40) * 32'h10000 + ofs;
				if (map_cfg.map_mode == cbad_pkg::MAP_EXHIROM && bank < 32'h80)
					lin = lin + 32'h400000;
				rom_window(lin, a.is_read, tgt, pos);
			end else if (ofs >= 32'h8000) begin
				rom_window((bank & 32'h3F) * 32'h10000 + ofs, a.is_read, tgt, pos);
			end else if (ofs < 32'(cbad_pkg::OFS_LOWRAM_END)) begin
				tgt = cbad_pkg::TGT_WRAM;
				pos = ofs;
			end else if (ofs >= 32'(cbad_pkg::OFS_IO_LO) && ofs < 32'(cbad_pkg::OFS_IO_HI)) begin
				tgt = cbad_pkg::TGT_IO;
				pos = ofs;
			end else if (ofs >= 32'(cbad_pkg::OFS_IO_HI) && map_cfg.sram_present) begin
				tgt = cbad_pkg::TGT_SRAM;
				pos = ((bank & 32'h1F) * 32'h2000 + ofs - 32'h6000) & 32'(map_cfg.sram_mask);
			end
		end
		r.target = tgt;
		r.phys_offset = pos[cbad_pkg::OFFS_W-1:0];
		r.write_enable = !a.is_read && (tgt == cbad_pkg::TGT_WRAM || tgt == cbad_pkg::TGT_SRAM
			|| tgt == cbad_pkg::TGT_IO);
		r.write_data_out = r.write_enable ? a.write_data : '0;
		return r;
	endfunction

	function automatic cbad_pkg::access_t mk_access(input logic [23:0] addr, input logic rd,
			input logic [7:0] wd);
		cbad_pkg::access_t a;
		a.bus_address = addr;
		a.is_read = rd;
		a.write_data = wd;
		return a;
	endfunction

	function automatic cbad_pkg::access_t rand_access();
		logic [7:0] bank;
		logic [15:0] ofs;
		case ($urandom_range(9))
			0: bank = $urandom_range(1) ? cbad_pkg::BANK_WRAM_LO : cbad_pkg::BANK_WRAM_HI;
			1, 2: bank = {1'($urandom_range(1)), 1'b0, 6'($urandom_range(63))};
			3: bank = 8'(32'h40 + $urandom_range(61));
			4: bank = {1'($urandom_range(1)), 7'(32'h70 + $urandom_range(13))};
			5: bank = 8'(32'hC0 + $urandom_range(63));
			default: bank = 8'($urandom_range(255));
		endcase
		case ($urandom_range(7))
			0: ofs = 16'($urandom_range(16'h1FFF));
			1: ofs = 16'(32'h1F80 + $urandom_range(16'h1FF));
			2: ofs = 16'(32'h2100 + $urandom_range(16'h3EFF));
			3: ofs = 16'(32'h5F00 + $urandom_range(16'h1FF));
			4: ofs = 16'(32'h6000 + $urandom_range(16'h1FFF));
			5: ofs = 16'(32'h7F00 + $urandom_range(16'h1FF));
			6: begin
				case ($urandom_range(9))
					0: ofs = 16'h0000;
					1: ofs = 16'h1FFF;
					2: ofs = 16'h2000;
					3: ofs = 16'h20FF;
					4: ofs = 16'h2100;
					5: ofs = 16'h5FFF;
					6: ofs = 16'h6000;
					7: ofs = 16'h7FFF;
					8: ofs = 16'h8000;
					default: ofs = 16'hFFFF;
				endcase
			end
			default: ofs = 16'($urandom_range(16'hFFFF));
		endcase
		return mk_access({bank, ofs}, 1'($urandom_range(1)), 8'($urandom_range(255)));
	endfunction

	task automatic send_access(input cbad_pkg::access_t a);
		bit hs;
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.bus_address <= a.bus_address;
		in_ch.is_read <= a.is_read;
		in_ch.write_data <= a.write_data;
		do begin
			@(negedge clk);
			hs = in_ch.ready;
			@(posedge clk);
		end while (!hs);
		pending_decodes.push_back(predict_decode(a));
		accesses_sent++;
	endtask

	task automatic drain_decodes();
		in_ch.valid <= 1'b0;
		while (pending_decodes.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input cbad_pkg::reg_index_t idx,
			input logic [cbad_pkg::CFG_W-1:0] data);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		unique case (idx)
			cbad_pkg::REG_MAP_MODE:
				map_cfg.map_mode = cbad_pkg::map_mode_t'(data[1:0]);
			cbad_pkg::REG_ROM_BYTES:
				map_cfg.rom_bytes = data[cbad_pkg::ROMSZ_W-1:0];
			cbad_pkg::REG_SRAM_PRESENT:
				map_cfg.sram_present = data[0];
			cbad_pkg::REG_SRAM_MASK:
				map_cfg.sram_mask = data[cbad_pkg::SMASK_W-1:0];
		endcase
	endtask

	// junk fills the unused upper bits of the narrow registers
	task automatic configure(input cbad_pkg::map_mode_t mode, input logic [23:0] rom,
			input logic present, input logic [19:0] mask, input logic [23:0] junk);
		drain_decodes();
		write_reg(cbad_pkg::REG_MAP_MODE, (junk & 24'hFFFFFC) | 24'(mode));
		write_reg(cbad_pkg::REG_ROM_BYTES, rom);
		write_reg(cbad_pkg::REG_SRAM_PRESENT, (junk & 24'hFFFFFE) | 24'(present));
		write_reg(cbad_pkg::REG_SRAM_MASK, (junk & 24'hF00000) | 24'(mask));
		cfg_write_en <= 1'b0;
		@(posedge clk);
		settings_applied++;
	endtask

	task automatic test_unmapped_after_reset();
		send_access(mk_access(24'h000000, 1'b0, 8'hFF));
		send_access(mk_access(24'hFFFFFF, 1'b1, 8'h00));
	endtask

	task automatic test_lorom_map();
		configure(cbad_pkg::MAP_LOROM, 24'h200000, 1'b1, 20'h07FFF, 24'h0);
		send_access(mk_access(24'h7E0000, 1'b0, 8'hA5));
		send_access(mk_access(24'h7FFFFF, 1'b1, 8'h5A));
		send_access(mk_access(24'h001FFF, 1'b0, 8'h3C));
		send_access(mk_access(24'h002000, 1'b1, 8'h00));
		send_access(mk_access(24'h0020FF, 1'b0, 8'h11));
		send_access(mk_access(24'h002100, 1'b0, 8'h22));
		send_access(mk_access(24'h805FFF, 1'b1, 8'h33));
		send_access(mk_access(24'h006000, 1'b1, 8'h44));
		send_access(mk_access(24'h808000, 1'b1, 8'h55));
		send_access(mk_access(24'h008000, 1'b0, 8'h66));
		send_access(mk_access(24'h400000, 1'b1, 8'h77));
		send_access(mk_access(24'h700000, 1'b0, 8'h88));
		send_access(mk_access(24'h7DFFFF, 1'b1, 8'h99));
		send_access(mk_access(24'hFFFFFF, 1'b1, 8'hAA));
	endtask

	task automatic test_hirom_map();
		configure(cbad_pkg::MAP_HIROM, 24'h400000, 1'b0, 20'h00000, 24'h0);
		send_access(mk_access(24'h006000, 1'b0, 8'hC3));
		send_access(mk_access(24'hC00000, 1'b1, 8'h00));
		send_access(mk_access(24'hFFFFFF, 1'b0, 8'hFF));
		send_access(mk_access(24'h3F8000, 1'b1, 8'h12));
	endtask

	task automatic test_exhirom_map();
		configure(cbad_pkg::MAP_EXHIROM, 24'h800000, 1'b1, 20'hFFFFF, 24'h0);
		send_access(mk_access(24'h400000, 1'b1, 8'h01));
		send_access(mk_access(24'h7DFFFF, 1'b0, 8'h02));
		send_access(mk_access(24'hC00000, 1'b1, 8'h03));
		send_access(mk_access(24'h808000, 1'b1, 8'h04));
		send_access(mk_access(24'h3F7FFF, 1'b0, 8'h05));
	endtask

	task automatic test_register_masking();
		configure(cbad_pkg::MAP_HIROM, 24'h000000, 1'b1, 20'h01FFF, 24'hFFFFFF);
		send_access(mk_access(24'h3F6000, 1'b0, 8'hE7));
		send_access(mk_access(24'hC00000, 1'b1, 8'h7E));
	endtask

	task automatic run_random_segment(input cbad_pkg::map_mode_t mode,
			input int unsigned items);
		logic [23:0] rom;
		logic [19:0] mask;
		case ($urandom_range(3))
			0: rom = 24'h000000;
			1: rom = 24'h800000;
			2: rom = 24'h1 << $urandom_range(23, 15);
			default: rom = 24'($urandom_range(24'h800000, 1));
		endcase
		case ($urandom_range(3))
			0: mask = 20'h00000;
			1: mask = 20'hFFFFF;
			2: mask = 20'((32'h1 << $urandom_range(20, 11)) - 1);
			default: mask = 20'($urandom_range(20'hFFFFF));
		endcase
		configure(mode, rom, 1'($urandom_range(1)), mask,
			$urandom_range(1) ? 24'($urandom) : 24'h0);
		repeat (items) send_access(rand_access());
	endtask

	task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct,
			input cbad_pkg::map_mode_t mode_a, input cbad_pkg::map_mode_t mode_b);
		drain_decodes();
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		run_random_segment(mode_a, 200);
		run_random_segment(mode_b, 200);
	endtask

	initial begin : result_checker
		cbad_pkg::result_t got;
		cbad_pkg::result_t want;
		bit take;
		out_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			take = out_ch.valid && out_ch.ready && arst_n;
			got.target = out_ch.target;
			got.phys_offset = out_ch.phys_offset;
			got.write_enable = out_ch.write_enable;
			got.write_data_out = out_ch.write_data_out;
			@(posedge clk);
			out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
			if (take) begin
				if (pending_decodes.size() == 0) begin
					decode_errors++;
					mismatch_reports++;
					if (mismatch_reports <= 10)
						$display("unexpected transfer: target %0d offset %h we %b data %h",
							got.target, got.phys_offset, got.write_enable,
							got.write_data_out);
				end else begin
					want = pending_decodes.pop_front();
					decodes_checked++;
					if (32'(want.target) < 6)
						target_hits[want.target]++;
					if (got.target !== want.target || got.phys_offset !== want.phys_offset
							|| got.write_enable !== want.write_enable
							|| got.write_data_out !== want.write_data_out) begin
						decode_errors++;
						mismatch_reports++;
						if (mismatch_reports <= 10)
							$display({"decode %0d: expected target %0d offset %h we %b ",
								"data %h, got target %0d offset %h we %b data %h"},
								decodes_checked, want.target, want.phys_offset,
								want.write_enable, want.write_data_out, got.target,
								got.phys_offset, got.write_enable, got.write_data_out);
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = cbad_pkg::REG_MAP_MODE;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.bus_address = '0;
		in_ch.is_read = 1'b0;
		in_ch.write_data = '0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		map_cfg.map_mode = cbad_pkg::MAP_NONE;
		map_cfg.rom_bytes = '0;
		map_cfg.sram_present = 1'b0;
		map_cfg.sram_mask = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unmapped_after_reset();
		test_lorom_map();
		test_hirom_map();
		test_exhirom_map();
		test_register_masking();
		test_random_traffic(0, 0, cbad_pkg::MAP_LOROM, cbad_pkg::MAP_HIROM);
		test_random_traffic(69, 0, cbad_pkg::MAP_EXHIROM, cbad_pkg::MAP_NONE);
		test_random_traffic(0, 69, cbad_pkg::MAP_LOROM, cbad_pkg::MAP_EXHIROM);
		test_random_traffic(38, 38, cbad_pkg::MAP_HIROM,
			cbad_pkg::map_mode_t'($urandom_range(3)));

		drain_decodes();
		repeat (5) @(posedge clk);
		$display("%0d accesses decoded under %0d register settings, %s",
			decodes_checked, settings_applied, "all map modes and stall mixes");
		$display("targets seen: wram %0d rom %0d sram %0d io %0d open %0d refused %0d",
			target_hits[0], target_hits[1], target_hits[2], target_hits[3],
			target_hits[4], target_hits[5]);
		if (decode_errors == 0)
			$display("cartridge_bus_address_decoder_unit regression: pass");
		else
			$display("cartridge_bus_address_decoder_unit regression: fail");
		$finish;
	end

endmodule
